// ===== design/id3_pkg.sv =====
// ---------------------------------------------------------------------------
// id3_pkg: shared constants, types and lookup functions
// Phase, event and kind codes for the ID3v2 text frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package id3_pkg;

	localparam int SIZE_BITS = 32;

	localparam int HDR_LEN  = 10;
	localparam int ID_LEN   = 4;
	localparam int SZ_LEN   = 4;
	localparam int TAIL_LEN = 3;

	localparam logic [7:0] SCAN_RESET = 8'd15;

	// config register indexes
	localparam logic REG_FRAMES_TO_SCAN = 1'b0;
	localparam int   ADDR_W             = 3;

	// parse phases
	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_ID      = 3'd1;
	localparam logic [2:0] PH_SIZE    = 3'd2;
	localparam logic [2:0] PH_TAIL    = 3'd3;
	localparam logic [2:0] PH_CONTENT = 3'd4;
	localparam logic [2:0] PH_SKIP    = 3'd5;

	// event codes
	localparam logic [2:0] EV_VERSION = 3'd0;
	localparam logic [2:0] EV_CONTENT = 3'd1;
	localparam logic [2:0] EV_NOT_ID3 = 3'd2;
	localparam logic [2:0] EV_EMPTY   = 3'd3;
	localparam logic [2:0] EV_UNKNOWN = 3'd4;

	localparam logic [3:0] KIND_UNKNOWN = 4'd8;

	typedef struct packed {
		logic       valid;
		logic [2:0] event_code;
		logic [2:0] frame_kind;
		logic [7:0] payload_byte;
		logic       last_in_frame;
		logic       parse_done;
	} id3_result_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		case (idx)
			2'd0:    magic_byte = 8'h49; // I
			2'd1:    magic_byte = 8'h44; // D
			default: magic_byte = 8'h33; // 3
		endcase
	endfunction

	function automatic logic [3:0] kind_of(input logic [31:0] id);
		case (id)
			32'h54495432: kind_of = 4'd0; // TIT2
			32'h54504531: kind_of = 4'd1; // TPE1
			32'h54414C42: kind_of = 4'd2; // TALB
			32'h54594552: kind_of = 4'd3; // TYER
			32'h54434F4E: kind_of = 4'd4; // TCON
			32'h54434F4D: kind_of = 4'd5; // TCOM
			32'h434F4D4D: kind_of = 4'd6; // COMM
			32'h5452434B: kind_of = 4'd7; // TRCK
			default:      kind_of = KIND_UNKNOWN;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== design/id3_if.sv =====
// ---------------------------------------------------------------------------
// id3_if: stream channels of the ID3v2 parser
// Byte channel in, event channel out; valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface id3_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source(output valid, output data_byte, output start_of_file, input ready);
	modport sink(input valid, input data_byte, input start_of_file, output ready);
endinterface

interface id3_event_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic [2:0] frame_kind;
	logic [7:0] payload_byte;
	logic       last_in_frame;
	logic       parse_done;

	modport source(output valid, output event_code, output frame_kind, output payload_byte,
		output last_in_frame, output parse_done, input ready);
	modport sink(input valid, input event_code, input frame_kind, input payload_byte,
		input last_in_frame, input parse_done, output ready);
endinterface

`default_nettype wire

// ===== design/id3_parse_core.sv =====
// ---------------------------------------------------------------------------
// id3_parse_core: per-byte parse state machine
// Holds the parse state and computes the event for one byte per cycle while step is high.
// ---------------------------------------------------------------------------
`default_nettype none

module id3_parse_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire logic [7:0]          data_byte,
	input  wire logic                start_of_file,
	input  wire logic [7:0]          frames_to_scan,
	output id3_pkg::id3_result_t     res
);
	import id3_pkg::*;

	logic [2:0]           phase_q, phase_d, phase_e;
	logic [3:0]           pos_q, pos_d, pos_e;
	logic [23:0]          id_q, id_d, id_e;
	logic [SIZE_BITS-1:0] size_q, size_d, size_e;
	logic [SIZE_BITS-1:0] rem_q, rem_d, rem_e;
	logic [7:0]           seen_q, seen_d, seen_e;
	logic [3:0]           kind_q, kind_d, kind_e;
	logic                 halted_q, halted_d, halted_e;

	logic [31:0]          id_full;
	logic [SIZE_BITS-1:0] rem_dec;
	logic [7:0]           seen_inc;
	logic                 done;
	logic                 fin;

	always_comb begin
		// start of file restarts the parse on this byte
		phase_e  = start_of_file ? PH_HEADER : phase_q;
		pos_e    = start_of_file ? 4'd0 : pos_q;
		id_e     = start_of_file ? 24'd0 : id_q;
		size_e   = start_of_file ? '0 : size_q;
		rem_e    = start_of_file ? '0 : rem_q;
		seen_e   = start_of_file ? 8'd0 : seen_q;
		kind_e   = start_of_file ? KIND_UNKNOWN : kind_q;
		halted_e = start_of_file ? 1'b0 : halted_q;

		phase_d  = phase_e;
		pos_d    = pos_e;
		id_d     = id_e;
		size_d   = size_e;
		rem_d    = rem_e;
		seen_d   = seen_e;
		kind_d   = kind_e;
		halted_d = halted_e;

		id_full  = {id_e, data_byte};
		rem_dec  = rem_e - 1'b1;
		seen_inc = seen_e + 8'd1;
		done     = (seen_inc >= frames_to_scan);
		fin      = 1'b0;

		res = '0;

		if (!halted_e) begin
			case (phase_e)
				PH_HEADER: begin
					if (pos_e < 4'd3 && data_byte != magic_byte(pos_e[1:0])) begin
						halted_d = 1'b1;
						res.valid      = 1'b1;
						res.event_code = EV_NOT_ID3;
						res.parse_done = 1'b1;
					end else begin
						if (pos_e == 4'(HDR_LEN - 1)) begin
							pos_d   = 4'd0;
							phase_d = PH_ID;
						end else begin
							pos_d = pos_e + 4'd1;
						end
						if (pos_e == 4'd3) begin
							res.valid        = 1'b1;
							res.event_code   = EV_VERSION;
							res.payload_byte = data_byte;
						end
					end
				end
				PH_ID: begin
					id_d = id_full[23:0];
					if (pos_e == 4'(ID_LEN - 1)) begin
						pos_d   = 4'd0;
						phase_d = PH_SIZE;
						kind_d  = kind_of(id_full);
					end else begin
						pos_d = pos_e + 4'd1;
					end
				end
				PH_SIZE: begin
					size_d = SIZE_BITS'({size_e, data_byte});
					if (pos_e == 4'(SZ_LEN - 1)) begin
						pos_d   = 4'd0;
						phase_d = PH_TAIL;
					end else begin
						pos_d = pos_e + 4'd1;
					end
				end
				PH_TAIL: begin
					if (pos_e == 4'(TAIL_LEN - 1)) begin
						pos_d = 4'd0;
						// size 0 or 1 means no content
						if (size_e <= SIZE_BITS'(1)) begin
							rem_d = '0;
							fin   = 1'b1;
							res.event_code = kind_e[3] ? EV_UNKNOWN : EV_EMPTY;
							res.frame_kind = kind_e[3] ? 3'd0 : kind_e[2:0];
						end else begin
							rem_d   = size_e - 1'b1;
							phase_d = kind_e[3] ? PH_SKIP : PH_CONTENT;
						end
					end else begin
						pos_d = pos_e + 4'd1;
					end
				end
				PH_CONTENT: begin
					rem_d = rem_dec;
					res.valid        = 1'b1;
					res.event_code   = EV_CONTENT;
					res.frame_kind   = kind_e[2:0];
					res.payload_byte = data_byte;
					fin = (rem_dec == '0);
				end
				PH_SKIP: begin
					rem_d = rem_dec;
					res.event_code = EV_UNKNOWN;
					fin = (rem_dec == '0);
				end
				default: begin
					halted_d = 1'b1;
				end
			endcase
		end

		if (fin) begin
			seen_d  = seen_inc;
			phase_d = PH_ID;
			pos_d   = 4'd0;
			res.valid         = 1'b1;
			res.last_in_frame = 1'b1;
			res.parse_done    = done;
			if (done) begin
				halted_d = 1'b1;
			end
		end

		if (!step) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= 4'd0;
			id_q     <= 24'd0;
			size_q   <= '0;
			rem_q    <= '0;
			seen_q   <= 8'd0;
			kind_q   <= KIND_UNKNOWN;
			halted_q <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			id_q     <= id_d;
			size_q   <= size_d;
			rem_q    <= rem_d;
			seen_q   <= seen_d;
			kind_q   <= kind_d;
			halted_q <= halted_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/id3v2_text_frame_parser.sv =====
// ---------------------------------------------------------------------------
// id3v2_text_frame_parser: ID3v2 text frame parser, top level
// Byte stream in, tagged text-frame events out, APB config port.
// ---------------------------------------------------------------------------
// Usage:
//   stream : one tag-file byte per request; start_of_file marks the first
//            byte of a file and restarts the parse on that byte.
//   events : zero or one event per byte (version, content byte, not ID3,
//            empty known frame, unknown frame skipped).
//   APB    : register frames_to_scan at byte address 0; write only while
//            the block is idle.
// Path: an accepted byte is registered in the input register, then parsed;
//   its event is registered in the event register.
// Throughput: one byte per cycle while the event register is free, set by
//   the single parse step between the input register and the event register.
// Reset: frames_to_scan returns to 15 and the parser halts; bytes are
//   dropped without events until a start_of_file byte arrives.
// Stall: a held event keeps the input register; stream.ready drops while
//   the input register is full and the event register holds a refused event.
// ---------------------------------------------------------------------------
`default_nettype none

module id3v2_text_frame_parser (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [id3_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output      logic [31:0]                prdata,
	output      logic                       pready,
	id3_byte_if.sink                        stream,
	id3_event_if.source                     events
);
	import id3_pkg::*;

	logic [7:0]  fts_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        sof_s1;
	logic        step;
	id3_result_t res;
	logic        out_valid_q;
	logic [2:0]  code_q;
	logic [2:0]  kind_q;
	logic [7:0]  payload_q;
	logic        last_q;
	logic        done_q;
	logic        out_free;

	// config register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FRAMES_TO_SCAN) ? {24'd0, fts_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fts_q <= SCAN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_FRAMES_TO_SCAN) begin
			fts_q <= pwdata[7:0];
		end
	end

	// input register
	assign out_free     = !out_valid_q || events.ready;
	assign step         = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.data_byte;
			sof_s1  <= stream.start_of_file;
		end
	end

	id3_parse_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.data_byte      (byte_s1),
		.start_of_file  (sof_s1),
		.frames_to_scan (fts_q),
		.res            (res)
	);

	// event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			code_q    <= res.event_code;
			kind_q    <= res.frame_kind;
			payload_q <= res.payload_byte;
			last_q    <= res.last_in_frame;
			done_q    <= res.parse_done;
		end
	end

	assign events.valid         = out_valid_q;
	assign events.event_code    = code_q;
	assign events.frame_kind    = kind_q;
	assign events.payload_byte  = payload_q;
	assign events.last_in_frame = last_q;
	assign events.parse_done    = done_q;

endmodule

`default_nettype wire
